[hdl/klut_pkg.sv]
`timescale 1ns / 1ps

package klut_pkg;

  // field widths of the request and response words
  localparam int unsigned CODE_W  = 32;
  localparam int unsigned INDEX_W = 10;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned KEY_W   = 2 * CODE_W;

  typedef logic [CODE_W-1:0]         code_t;
  typedef logic [INDEX_W-1:0]        index_t;
  typedef logic [COUNT_W-1:0]        count_t;
  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [KEY_W-1:0]          key_t;

  // command codes
  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } command_e;

  // signed 16-bit clamp bounds
  localparam value_t SAT_MAX = 32'sd32767;
  localparam value_t SAT_MIN = -32'sd32768;

endpackage

[hdl/klut_if.sv]
`timescale 1ns / 1ps

// request word: table write or pair query
interface klut_req_if;
  logic              valid;
  logic              ready;
  klut_pkg::command_e command;
  klut_pkg::index_t  entry_index;
  klut_pkg::code_t   first_code;
  klut_pkg::code_t   second_code;
  klut_pkg::value_t  kern_value;

  modport source (
    output valid, command, entry_index, first_code, second_code, kern_value,
    input  ready
  );
  modport sink (
    input  valid, command, entry_index, first_code, second_code, kern_value,
    output ready
  );
endinterface

// response word: adjustment for a query
interface klut_rsp_if;
  logic             valid;
  logic             ready;
  klut_pkg::value_t kern_adjust;
  logic             pair_found;

  modport source (output valid, kern_adjust, pair_found, input ready);
  modport sink (input valid, kern_adjust, pair_found, output ready);
endinterface

// configuration word: entry count
interface klut_cfg_if;
  logic             valid;
  logic             ready;
  klut_pkg::count_t data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

[hdl/kerning_pair_lookup.sv]
`timescale 1ns / 1ps
// write word: taken while the sequencer is idle, the request side stays ready
// query word: a probe and a compare state per halving step of the lower-bound search,
//   then a fetch of the lower bound and a check against the key, paced by
//   the single registered read port of the table ram
// one query in flight at a time; the response register frees the input side
// reset: entry count cleared, sequencer idle, table contents undefined

module kerning_pair_lookup #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned ASCII_LIMIT = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  klut_cfg_if.sink   cfg_i,
  klut_req_if.sink   req_i,
  klut_rsp_if.source rsp_o
);

  // table address and span widths
  localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);
  localparam int unsigned SPAN_W = $clog2(TABLE_DEPTH + 1);
  // common width for comparing register fields against the depth
  localparam int unsigned CMP_W  = (SPAN_W > klut_pkg::COUNT_W) ? SPAN_W
                                                                : klut_pkg::COUNT_W;
  localparam int unsigned ROW_W  = klut_pkg::KEY_W + klut_pkg::VALUE_W;

  localparam logic [CMP_W-1:0]          DEPTH_C = CMP_W'(TABLE_DEPTH);
  localparam logic [klut_pkg::CODE_W-1:0] LIMIT_C = klut_pkg::CODE_W'(ASCII_LIMIT);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_COMPARE,
    ST_CHECK
  } state_e;

  state_e state_q, state_d;

  // search registers
  klut_pkg::key_t    key_q, key_d;
  logic              small_q, small_d;     // both codes below the ascii limit
  logic [SPAN_W-1:0] lo_q, lo_d;
  logic [SPAN_W-1:0] span_q, span_d;
  logic [SPAN_W-1:0] count_q, count_d;    // clamped entry count of this query
  logic              fetch_ok_q, fetch_ok_d;

  // configuration
  klut_pkg::count_t  entry_count_q, entry_count_d;

  // response register
  logic              rsp_valid_q, rsp_valid_d;
  klut_pkg::value_t  rsp_adjust_q, rsp_adjust_d;
  logic              rsp_found_q, rsp_found_d;

  // ram ports
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ROW_W-1:0]  ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [ROW_W-1:0]  ram_rdata;

  klut_pkg::key_t    row_key;
  klut_pkg::value_t  row_value;
  klut_pkg::value_t  sat_value;

  logic [SPAN_W-1:0] half;
  logic [SPAN_W-1:0] mid;
  logic              req_fire;
  logic              rsp_free;
  logic              hit;
  logic [CMP_W-1:0]  cfg_count_ext;
  logic [CMP_W-1:0]  widx_ext;

  // key and adjustment in one ram row
  klut_ram #(
    .WIDTH (ROW_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign row_key   = ram_rdata[ROW_W-1 -: klut_pkg::KEY_W];
  assign row_value = klut_pkg::value_t'(ram_rdata[klut_pkg::VALUE_W-1:0]);

  // config is always taken
  assign cfg_i.ready   = 1'b1;
  assign entry_count_d = (cfg_i.valid) ? cfg_i.data : entry_count_q;

  // request side only open while the sequencer is idle
  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;

  // table write straight from the request word, slots past the depth dropped
  assign widx_ext  = CMP_W'(req_i.entry_index);
  assign ram_we    = req_fire && (req_i.command == klut_pkg::CMD_WRITE)
                     && (widx_ext < DEPTH_C);
  assign ram_waddr = ADDR_W'(req_i.entry_index);
  assign ram_wdata = {req_i.first_code, req_i.second_code, req_i.kern_value};

  assign cfg_count_ext = CMP_W'(entry_count_q);

  // middle of the remaining span
  assign half = span_q >> 1;
  assign mid  = lo_q + half;

  // saturate to the signed 16-bit range
  always_comb begin
    if (row_value > klut_pkg::SAT_MAX) begin
      sat_value = klut_pkg::SAT_MAX;
    end else if (row_value < klut_pkg::SAT_MIN) begin
      sat_value = klut_pkg::SAT_MIN;
    end else begin
      sat_value = row_value;
    end
  end

  assign hit      = fetch_ok_q && (row_key == key_q);
  assign rsp_free = !rsp_valid_q || rsp_o.ready;

  always_comb begin
    state_d      = state_q;
    key_d        = key_q;
    small_d      = small_q;
    lo_d         = lo_q;
    span_d       = span_q;
    count_d      = count_q;
    fetch_ok_d   = fetch_ok_q;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rsp_adjust_d = rsp_adjust_q;
    rsp_found_d  = rsp_found_q;
    ram_re       = 1'b0;
    ram_raddr    = ADDR_W'(mid);

    unique case (state_q)
      ST_IDLE: begin
        if (req_fire && (req_i.command == klut_pkg::CMD_QUERY)) begin
          key_d   = {req_i.first_code, req_i.second_code};
          small_d = (req_i.first_code < LIMIT_C) && (req_i.second_code < LIMIT_C);
          lo_d    = '0;
          // counts above the depth search the whole table
          if (cfg_count_ext > DEPTH_C) begin
            count_d = SPAN_W'(TABLE_DEPTH);
            span_d  = SPAN_W'(TABLE_DEPTH);
          end else begin
            count_d = SPAN_W'(entry_count_q);
            span_d  = SPAN_W'(entry_count_q);
          end
          state_d = ST_PROBE;
        end
      end

      ST_PROBE: begin
        if (span_q != '0) begin
          // read the middle entry
          ram_re    = 1'b1;
          ram_raddr = ADDR_W'(mid);
          state_d   = ST_COMPARE;
        end else begin
          // span exhausted: fetch the lower bound if it lies inside the table
          fetch_ok_d = (lo_q < count_q);
          ram_re     = (lo_q < count_q);
          ram_raddr  = ADDR_W'(lo_q);
          state_d    = ST_CHECK;
        end
      end

      ST_COMPARE: begin
        if (row_key < key_q) begin
          lo_d   = mid + SPAN_W'(1);
          span_d = span_q - half - SPAN_W'(1);
        end else begin
          span_d = half;
        end
        state_d = ST_PROBE;
      end

      ST_CHECK: begin
        // hold the ram data until the response register frees up
        if (rsp_free) begin
          rsp_valid_d  = 1'b1;
          rsp_found_d  = hit;
          if (!hit) begin
            rsp_adjust_d = '0;
          end else if (small_q) begin
            rsp_adjust_d = sat_value;
          end else begin
            rsp_adjust_d = row_value;
          end
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      entry_count_q <= '0;
      rsp_valid_q   <= 1'b0;
      key_q         <= '0;
      small_q       <= 1'b0;
      lo_q          <= '0;
      span_q        <= '0;
      count_q       <= '0;
      fetch_ok_q    <= 1'b0;
      rsp_adjust_q  <= '0;
      rsp_found_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      entry_count_q <= entry_count_d;
      rsp_valid_q   <= rsp_valid_d;
      key_q         <= key_d;
      small_q       <= small_d;
      lo_q          <= lo_d;
      span_q        <= span_d;
      count_q       <= count_d;
      fetch_ok_q    <= fetch_ok_d;
      rsp_adjust_q  <= rsp_adjust_d;
      rsp_found_q   <= rsp_found_d;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.kern_adjust = rsp_adjust_q;
  assign rsp_o.pair_found  = rsp_found_q;

endmodule

[hdl/klut_ram.sv]
`timescale 1ns / 1ps

module klut_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[test/kerning_pair_lookup_test.sv]
`timescale 1ns / 1ps

module kerning_pair_lookup_test;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned ASCII_LIMIT = 128;
  // quiet cycles before a count write and at the end, above the worst query time
  localparam int SETTLE = 40;
  localparam int TOTAL_WORDS = 1250;

  // one expected response word
  typedef struct packed {
    klut_pkg::value_t adjust;
    logic             found;
  } reply_t;

  // mirror of the pair table, the entry count and the replies still owed
  class pair_table_tracker;
    klut_pkg::key_t   keys [TABLE_DEPTH];
    klut_pkg::value_t vals [TABLE_DEPTH];
    klut_pkg::count_t entry_count;
    reply_t           awaited [$];
    int               failures;

    function new();
      entry_count = '0;
      failures    = 0;
    endfunction

    function void set_count(klut_pkg::count_t c);
      entry_count = c;
    endfunction

    function int unsigned searched_span();
      return (entry_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count);
    endfunction

    // lower-bound search over the first entries, then the ascii clamp on a hit
    function reply_t search_adjust(klut_pkg::code_t a, klut_pkg::code_t b);
      klut_pkg::key_t   key;
      int unsigned      limit, lo, span, half, mid;
      klut_pkg::value_t v;
      reply_t           r;
      key   = {a, b};
      limit = searched_span();
      lo    = 0;
      span  = limit;
      while (span > 0) begin
        half = span / 2;
        mid  = lo + half;
        if (keys[mid] < key) begin
          lo   = mid + 1;
          span = span - (half + 1);
        end else begin
          span = half;
        end
      end
      r.adjust = '0;
      r.found  = 1'b0;
      if (lo < limit && keys[lo] == key) begin
        v = vals[lo];
        if (a < ASCII_LIMIT && b < ASCII_LIMIT) begin
          if (v > klut_pkg::SAT_MAX) v = klut_pkg::SAT_MAX;
          else if (v < klut_pkg::SAT_MIN) v = klut_pkg::SAT_MIN;
        end
        r.adjust = v;
        r.found  = 1'b1;
      end
      return r;
    endfunction

    // an accepted request word: store an entry or owe a reply
    function void note_word(klut_pkg::command_e cmd, klut_pkg::index_t idx,
                            klut_pkg::code_t a, klut_pkg::code_t b,
                            klut_pkg::value_t v);
      if (cmd == klut_pkg::CMD_WRITE) begin
        keys[idx] = {a, b};
        vals[idx] = v;
      end else begin
        awaited.insert(awaited.size(), search_adjust(a, b));
      end
    endfunction

    function void check_reply(klut_pkg::value_t adj, logic found);
      reply_t e;
      if (awaited.size() == 0) begin
        $error("reply with no query waiting: kern_adjust %0d pair_found %0b", adj, found);
        failures++;
        return;
      end
      e = awaited.pop_front();
      if (adj !== e.adjust) begin
        $error("kern_adjust: expected %0d, got %0d", e.adjust, adj);
        failures++;
      end
      if (found !== e.found) begin
        $error("pair_found: expected %0b, got %0b", e.found, found);
        failures++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  klut_cfg_if cfg_bus ();
  klut_req_if req_bus ();
  klut_rsp_if rsp_bus ();

  pair_table_tracker tracker = new();

  // calm phases give stretches with no idling on one side
  bit calm_req;
  bit calm_rsp;
  int words_sent;

  kerning_pair_lookup #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .ASCII_LIMIT(ASCII_LIMIT)
  ) u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_i (cfg_bus),
    .req_i (req_bus),
    .rsp_o (rsp_bus)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // idle cycles before one word, zero on a calm side
  function automatic int draw_gap(bit calm);
    if (calm || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 18);
  endfunction

  // character codes: ascii, the ascii edge, wide, extremes
  function automatic klut_pkg::code_t pick_code();
    case ($urandom_range(0, 6))
      0, 1: return klut_pkg::code_t'($urandom_range(0, 127));
      2: return klut_pkg::code_t'($urandom_range(120, 135));
      3, 4: return klut_pkg::code_t'($urandom);
      5: begin
        case ($urandom_range(0, 3))
          0: return 32'h0000_0000;
          1: return 32'hffff_ffff;
          2: return 32'h7fff_ffff;
          default: return 32'h8000_0000;
        endcase
      end
      default: return klut_pkg::code_t'($urandom_range(0, 600));
    endcase
  endfunction

  // adjustments around the 16-bit clamp and at the 32-bit extremes
  function automatic klut_pkg::value_t pick_value();
    case ($urandom_range(0, 5))
      0, 1: return klut_pkg::value_t'($urandom);
      2: return klut_pkg::value_t'($urandom_range(0, 80000) - 40000);
      3: return ($urandom_range(0, 1) == 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      4: begin
        case ($urandom_range(0, 3))
          0: return 32'sd32767;
          1: return 32'sd32768;
          2: return -32'sd32768;
          default: return -32'sd32769;
        endcase
      end
      default: return klut_pkg::value_t'($urandom_range(0, 200) - 100);
    endcase
  endfunction

  // one request word, valid held until the handshake
  task automatic send_word(klut_pkg::command_e cmd, klut_pkg::index_t idx,
                           klut_pkg::code_t a, klut_pkg::code_t b,
                           klut_pkg::value_t v);
    int gap;
    gap = draw_gap(calm_req);
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid       <= 1'b1;
    req_bus.command     <= cmd;
    req_bus.entry_index <= idx;
    req_bus.first_code  <= a;
    req_bus.second_code <= b;
    req_bus.kern_value  <= v;
    do @(posedge clk); while (!req_bus.ready);
    tracker.note_word(cmd, idx, a, b, v);
    words_sent++;
  endtask

  // count write only once every reply is in and the search has settled
  task automatic set_count(klut_pkg::count_t c);
    req_bus.valid <= 1'b0;
    while (tracker.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= c;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    tracker.set_count(c);
  endtask

  // rewrite the low slots, ascending and unique unless asked otherwise
  task automatic load_entries(input int n, input bit ordered, output int m);
    klut_pkg::key_t row [$];
    klut_pkg::key_t k;
    int             pos;
    for (int i = 0; i < n; i++) begin
      k = {pick_code(), pick_code()};
      if (!ordered) begin
        row.insert(row.size(), k);
      end else begin
        pos = 0;
        while (pos < row.size() && row[pos] < k) pos++;
        if (pos == row.size() || row[pos] != k) row.insert(pos, k);
      end
    end
    foreach (row[i]) begin
      send_word(klut_pkg::CMD_WRITE, klut_pkg::index_t'(i), row[i][63:32], row[i][31:0],
                pick_value());
    end
    m = row.size();
  endtask

  // queries: mostly stored pairs, then neighbours and fresh pairs
  task automatic run_queries(int n);
    int unsigned    span;
    int             pick;
    klut_pkg::key_t k;
    for (int i = 0; i < n; i++) begin
      span = tracker.searched_span();
      pick = $urandom_range(0, 9);
      if (pick < 5 && span > 0) begin
        k = tracker.keys[$urandom_range(0, span - 1)];
      end else if (pick < 7 && span > 0) begin
        k = tracker.keys[$urandom_range(0, span - 1)];
        k = ($urandom_range(0, 1) == 1) ? k + 1 : k - 1;
      end else begin
        k = {pick_code(), pick_code()};
      end
      send_word(klut_pkg::CMD_QUERY, klut_pkg::index_t'($urandom), k[63:32], k[31:0],
                klut_pkg::value_t'($urandom));
    end
  endtask

  // response side: random stalls, every reply checked in order
  initial begin
    int gap;
    rsp_bus.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      gap = draw_gap(calm_rsp);
      if (gap > 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_bus.ready <= 1'b1;
      do @(posedge clk); while (!rsp_bus.valid);
      tracker.check_reply(rsp_bus.kern_adjust, rsp_bus.pair_found);
    end
  end

  // directed table: clamp edges on ascii pairs, raw values elsewhere
  klut_pkg::code_t  dir_first  [8] = '{32'd0, 32'd0, 32'd5, 32'd65, 32'd86, 32'd127,
                                       32'd128, 32'hffff_ffff};
  klut_pkg::code_t  dir_second [8] = '{32'd0, 32'd127, 32'd65, 32'd86, 32'd65, 32'd128,
                                       32'd0, 32'hffff_ffff};
  klut_pkg::value_t dir_value  [8] = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sd32768,
                                       -32'sd5, -32'sd32769, -32'sd32769,
                                       32'sh8000_0000, 32'sh7fff_ffff};

  initial begin
    int               m, n, waited;
    klut_pkg::count_t c;
    rst_n               <= 1'b0;
    calm_req            = 1'b0;
    calm_rsp            = 1'b0;
    words_sent          = 0;
    cfg_bus.valid       <= 1'b0;
    cfg_bus.data        <= '0;
    req_bus.valid       <= 1'b0;
    req_bus.command     <= klut_pkg::CMD_WRITE;
    req_bus.entry_index <= '0;
    req_bus.first_code  <= '0;
    req_bus.second_code <= '0;
    req_bus.kern_value  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table after reset, nothing can hit
    send_word(klut_pkg::CMD_QUERY, '0, 32'h0, 32'h0, '0);
    send_word(klut_pkg::CMD_QUERY, '1, 32'hffff_ffff, 32'hffff_ffff, '1);

    for (int i = 0; i < 8; i++) begin
      send_word(klut_pkg::CMD_WRITE, klut_pkg::index_t'(i), dir_first[i], dir_second[i],
                dir_value[i]);
    end
    set_count(klut_pkg::count_t'(8));
    for (int i = 0; i < 8; i++) begin
      send_word(klut_pkg::CMD_QUERY, klut_pkg::index_t'(i), dir_first[i], dir_second[i],
                '0);
    end
    // misses between entries, just below the top entry and between two ascii pairs
    send_word(klut_pkg::CMD_QUERY, '0, 32'd0, 32'd1, '0);
    send_word(klut_pkg::CMD_QUERY, '0, 32'hffff_ffff, 32'hffff_fffe, '0);
    send_word(klut_pkg::CMD_QUERY, '0, 32'd65, 32'd65, '0);
    // a shorter count hides the upper entries
    set_count(klut_pkg::count_t'(5));
    send_word(klut_pkg::CMD_QUERY, '0, 32'd127, 32'd128, '0);
    send_word(klut_pkg::CMD_QUERY, '0, 32'd86, 32'd65, '0);

    // whole table: ascii pairs in the lower half, wide codes above
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (i < TABLE_DEPTH / 2) begin
        send_word(klut_pkg::CMD_WRITE, klut_pkg::index_t'(i), klut_pkg::code_t'(i >> 3),
                  klut_pkg::code_t'((i % 8) * 16 + $urandom_range(0, 15)), pick_value());
      end else begin
        send_word(klut_pkg::CMD_WRITE, klut_pkg::index_t'(i), klut_pkg::code_t'(i << 22),
                  klut_pkg::code_t'($urandom), pick_value());
      end
    end
    set_count(klut_pkg::count_t'(TABLE_DEPTH));
    run_queries(40);
    // counts past the depth search the full table
    set_count('1);
    run_queries(20);
    set_count('0);
    run_queries(5);

    while (words_sent < TOTAL_WORDS) begin
      calm_req = ($urandom_range(0, 4) == 0);
      calm_rsp = ($urandom_range(0, 4) == 0);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 24);
      if ($urandom_range(0, 9) == 0) n = 0;
      load_entries(n, $urandom_range(0, 6) != 0, m);
      // stale entries beyond the fresh ones were all written by the full load
      case ($urandom_range(0, 19))
        0, 1: c = klut_pkg::count_t'($urandom_range(0, m));
        2, 3: c = klut_pkg::count_t'($urandom_range(m, TABLE_DEPTH));
        4:    c = '0;
        5:    c = klut_pkg::count_t'($urandom_range(TABLE_DEPTH + 1, 2047));
        default: c = klut_pkg::count_t'(m);
      endcase
      set_count(c);
      run_queries($urandom_range(4, 30));
    end

    req_bus.valid <= 1'b0;
    waited = 0;
    while (tracker.awaited.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE) @(posedge clk);
    if (tracker.awaited.size() != 0) begin
      $error("%0d replies never arrived", tracker.awaited.size());
      tracker.failures++;
    end
    if (tracker.failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
